>>> hw/rtl/lfsr_pkg.sv
// Package: types and constants for the line follower steering ramp.
package lfsr_pkg;

   localparam int DUTY_BITS = 8;
   localparam int CFG_BITS  = 8;
   localparam int CMP_BITS  = ((DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS) + 1;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CFG_BITS-1:0] SPEED_STRAIGHT_RST    = CFG_BITS'(210);
   localparam logic [CFG_BITS-1:0] SPEED_LIGHT_TURN_RST  = CFG_BITS'(150);
   localparam logic [CFG_BITS-1:0] SPEED_STRONG_TURN_RST = CFG_BITS'(90);
   localparam logic [CFG_BITS-1:0] SPEED_PIVOT_RST       = CFG_BITS'(60);
   localparam logic [CFG_BITS-1:0] SPEED_SEARCH_RST      = CFG_BITS'(120);
   localparam logic [CFG_BITS-1:0] RAMP_STEP_RST         = CFG_BITS'(25);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPEED_STRAIGHT    = 3'd0,
      CSR_SPEED_LIGHT_TURN  = 3'd1,
      CSR_SPEED_STRONG_TURN = 3'd2,
      CSR_SPEED_PIVOT       = 3'd3,
      CSR_SPEED_SEARCH      = 3'd4,
      CSR_RAMP_STEP         = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_CENTER = 2'd1,
      SIDE_RIGHT  = 2'd2
   } side_type;

   typedef struct packed {
      logic sense_left;
      logic sense_center;
      logic sense_right;
   } req_item_type;

   typedef struct packed {
      logic [7:0] duty_left;
      logic [7:0] duty_right;
   } rsp_item_type;

endpackage

>>> hw/rtl/line_follower_steering_ramp.sv
// Line follower steering: sensor decode, target duties and ramp limiting.
// Datapath: an accepted req_ item is held in the input register, then decoded and slewed
// into the duty registers that drive rsp_item. Throughput: one item per cycle unless
// rsp_stall holds the output; the duty registers hold while a waiting result is stalled.
// Reset (synchronous): duties 0, last side center, registers to their defaults.
module line_follower_steering_ramp
   import lfsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_item_type              rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   logic [CFG_BITS-1:0] speed_straight_ff, speed_light_turn_ff, speed_strong_turn_ff;
   logic [CFG_BITS-1:0] speed_pivot_ff, speed_search_ff, ramp_step_ff;

   logic                 in_valid_ff, in_valid_in;
   req_item_type         in_item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0] duty_left_ff, duty_left_in;
   logic [DUTY_BITS-1:0] duty_right_ff, duty_right_in;
   side_type             last_side_ff, last_side_in;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic [CFG_BITS-1:0]  target_left, target_right;

   function automatic logic [DUTY_BITS-1:0] slew(input logic [DUTY_BITS-1:0] now,
                                                 input logic [DUTY_BITS-1:0] target,
                                                 input logic [CFG_BITS-1:0]  step);
      logic [DUTY_BITS-1:0] diff;
      logic                 in_reach;
      logic [DUTY_BITS-1:0] step_d;
      diff     = (target > now) ? (target - now) : (now - target);
      in_reach = CMP_BITS'(diff) <= CMP_BITS'(step);
      step_d   = DUTY_BITS'(step);
      if (target == now || in_reach) begin
         return target;
      end else if (target > now) begin
         return now + step_d;
      end else begin
         return now - step_d;
      end
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_straight_ff    <= SPEED_STRAIGHT_RST;
         speed_light_turn_ff  <= SPEED_LIGHT_TURN_RST;
         speed_strong_turn_ff <= SPEED_STRONG_TURN_RST;
         speed_pivot_ff       <= SPEED_PIVOT_RST;
         speed_search_ff      <= SPEED_SEARCH_RST;
         ramp_step_ff         <= RAMP_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED_STRAIGHT:    speed_straight_ff    <= csr_data;
            CSR_SPEED_LIGHT_TURN:  speed_light_turn_ff  <= csr_data;
            CSR_SPEED_STRONG_TURN: speed_strong_turn_ff <= csr_data;
            CSR_SPEED_PIVOT:       speed_pivot_ff       <= csr_data;
            CSR_SPEED_SEARCH:      speed_search_ff      <= csr_data;
            CSR_RAMP_STEP:         ramp_step_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !out_free);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // decode, one target pair per sensor pattern
   always_comb begin
      last_side_in = last_side_ff;
      unique case ({in_item_ff.sense_left, in_item_ff.sense_center,
                    in_item_ff.sense_right}) inside
         3'b010: begin
            target_left  = speed_straight_ff;
            target_right = speed_straight_ff;
            last_side_in = SIDE_CENTER;
         end
         3'b001: begin
            target_left  = speed_strong_turn_ff;
            target_right = speed_pivot_ff;
            last_side_in = SIDE_RIGHT;
         end
         3'b100: begin
            target_left  = speed_pivot_ff;
            target_right = speed_strong_turn_ff;
            last_side_in = SIDE_LEFT;
         end
         3'b011: begin
            target_left  = speed_straight_ff;
            target_right = speed_light_turn_ff;
            last_side_in = SIDE_RIGHT;
         end
         3'b110: begin
            target_left  = speed_light_turn_ff;
            target_right = speed_straight_ff;
            last_side_in = SIDE_LEFT;
         end
         3'b111: begin
            target_left  = speed_straight_ff;
            target_right = speed_straight_ff;
         end
         3'b000, 3'b101: begin
            // line lost: search toward the last side, center counts as right
            if (last_side_ff != SIDE_LEFT) begin
               target_left  = speed_search_ff;
               target_right = '0;
            end else begin
               target_left  = '0;
               target_right = speed_search_ff;
            end
         end
         default: begin
            target_left  = '0;
            target_right = '0;
         end
      endcase
      duty_left_in  = slew(duty_left_ff, DUTY_BITS'(target_left), ramp_step_ff);
      duty_right_in = slew(duty_right_ff, DUTY_BITS'(target_right), ramp_step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         duty_left_ff  <= '0;
         duty_right_ff <= '0;
         last_side_ff  <= SIDE_CENTER;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            duty_left_ff  <= duty_left_in;
            duty_right_ff <= duty_right_in;
            last_side_ff  <= last_side_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item.duty_left  = 8'(duty_left_ff);
   assign rsp_item.duty_right = 8'(duty_right_ff);

`ifndef ASSERT_OFF
   logic [DUTY_BITS-1:0] dl_delta;
   assign dl_delta = (duty_left_in > duty_left_ff) ? (duty_left_in - duty_left_ff)
                                                   : (duty_left_ff - duty_left_in);

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   a_duties_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(duty_left_ff) && $stable(duty_right_ff)))
      else $error("duty changed while item waits");

   a_ramp_limit: assert property (@(posedge clock) disable iff (reset)
      advance |-> (CMP_BITS'(dl_delta) <= CMP_BITS'(ramp_step_ff)))
      else $error("left duty step exceeds ramp step");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item not presented");
`endif

endmodule
